// ===== rtl/rc5_block_cipher_top_defines.svh =====
// assertion macros shared by the rc5 block cipher rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef RC5_BLOCK_CIPHER_TOP_DEFINES_SVH
`define RC5_BLOCK_CIPHER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define RC5_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define RC5_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rc5_pkg.sv =====
// types, constants and codes for the rc5 block cipher
// no dependencies; imported by rc5_block_cipher_top, rc5_alu and rc5_seq
`timescale 1ns / 1ps

package rc5_pkg;

   // default cipher shape
   localparam int RC5_ROUNDS    = 12;
   localparam int RC5_KEY_BYTES = 16;
   localparam int WORD_W        = 32;
   localparam int KEY_REG_W     = 64;
   localparam int MIX_PASSES    = 3;

   // key schedule magic numbers
   localparam logic [WORD_W-1:0] MAGIC_P = 32'hb7e15163;
   localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9e3779b9;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 1'd1;

   // command codes
   localparam logic [1:0] CMD_EXPAND  = 2'd0;
   localparam logic [1:0] CMD_ENCRYPT = 2'd1;
   localparam logic [1:0] CMD_DECRYPT = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [WORD_W-1:0] word_a;
      logic [WORD_W-1:0] word_b;
   } req_word_type;

   typedef struct packed {
      logic [WORD_W-1:0] out_a;
      logic [WORD_W-1:0] out_b;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INIT,
      ST_MIX_A,
      ST_MIX_B,
      ST_ENC,
      ST_DEC
   } state_type;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_ENC,
      OP_DEC,
      OP_MIX_A,
      OP_MIX_B
   } alu_op_type;

   // source of the third alu operand
   typedef enum logic [1:0] {
      SSEL_RAM,
      SSEL_KEY,
      SSEL_MAGIC
   } s_sel_type;

   // source of subkey table write data
   typedef enum logic [1:0] {
      WSEL_ZERO,
      WSEL_ACC,
      WSEL_ALU
   } wd_sel_type;

   // sequencer to datapath control
   typedef struct packed {
      alu_op_type op;
      logic       swap;
      s_sel_type  s_sel;
      logic       a_we;
      logic       b_we;
      logic       l_we;
      logic       ld_req;
      logic       ld_magic;
      logic       l_load;
      logic       ab_clr;
      logic       ram_we;
      wd_sel_type wd_sel;
      logic       rsp_fire;
   } ctl_type;

endpackage

// ===== rtl/rc5_block_cipher_top.sv =====
// top level of the rc5-32 block cipher: key registers, datapath, subkey table
// depends on rc5_pkg, rc5_ram, rc5_alu, rc5_seq and rc5_block_cipher_top_defines.svh
//
//   channel   ports                          handshake
//   request   start, busy, req_word          taken when start and not busy
//   response  rsp_strobe, rsp_word           one cycle strobe, no back pressure
//   csr       csr_we, csr_index, csr_wdata   written when csr_we is high
//
// with T = 2*ROUNDS+2 table words: encrypt and decrypt step through the T
// subkeys on the shared alu, one half round per cycle, and the strobe follows in
// the next cycle, during which a new word may already be taken.
// key expansion fills the T table words, then runs three passes of T mixing
// steps, two alu passes per step, and gives no response word.
// after reset a clearing pass writes zero to the T table entries, one per
// cycle, with busy high; csr writes are taken throughout.
`timescale 1ns / 1ps
`include "rc5_block_cipher_top_defines.svh"

module rc5_block_cipher_top
   import rc5_pkg::*;
#(
   parameter int ROUNDS    = RC5_ROUNDS,
   parameter int KEY_BYTES = RC5_KEY_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_word_type         req_word,
   output logic                 rsp_strobe,
   output rsp_word_type         rsp_word,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_REG_W-1:0] csr_wdata
);

   localparam int TABLE_WORDS = 2 * ROUNDS + 2;
   localparam int ADDR_W      = $clog2(TABLE_WORDS);
   localparam int KEY_WORDS   = (KEY_BYTES + 3) / 4;
   localparam int KIDX_W      = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

   logic [KEY_REG_W-1:0] key_low_ff, key_high_ff;
   logic [WORD_W-1:0]    a_ff, a_in, b_ff, b_in;
   logic [WORD_W-1:0]    l_ff [KEY_WORDS];
   logic [WORD_W-1:0]    l_in [KEY_WORDS];
   logic [WORD_W-1:0]    key_word [KEY_WORDS];
   logic                 rsp_strobe_ff;

   ctl_type              ctl;
   logic [ADDR_W-1:0]    raddr, waddr;
   logic [KIDX_W-1:0]    l_idx;
   logic [WORD_W-1:0]    ram_rdata, ram_wdata;
   logic [WORD_W-1:0]    alu_x, alu_y, alu_s, alu_res;
   logic [2*KEY_REG_W-1:0] key_bytes;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            default:      key_low_ff  <= key_low_ff;
         endcase
      end
   end

   // key bytes packed little endian into words, bytes past the key length read zero
   assign key_bytes = {key_high_ff, key_low_ff};
   always_comb begin
      for (int w = 0; w < KEY_WORDS; w++) begin
         for (int n = 0; n < 4; n++) begin
            key_word[w][8*n +: 8] = ((4*w + n) < KEY_BYTES) ?
                                    key_bytes[8*(4*w + n) +: 8] : 8'h00;
         end
      end
   end

   rc5_seq #(
      .TABLE_WORDS (TABLE_WORDS),
      .KEY_WORDS   (KEY_WORDS)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cmd   (req_word.cmd),
      .busy  (busy),
      .ctl   (ctl),
      .raddr (raddr),
      .waddr (waddr),
      .l_idx (l_idx)
   );

   // operand select for the shared unit
   assign alu_x = ctl.swap ? b_ff : a_ff;
   assign alu_y = ctl.swap ? a_ff : b_ff;
   always_comb begin
      case (ctl.s_sel)
         SSEL_RAM:   alu_s = ram_rdata;
         SSEL_KEY:   alu_s = l_ff[l_idx];
         SSEL_MAGIC: alu_s = MAGIC_Q;
         default:    alu_s = ram_rdata;
      endcase
   end

   rc5_alu u_alu (
      .op  (ctl.op),
      .x   (alu_x),
      .y   (alu_y),
      .s   (alu_s),
      .res (alu_res)
   );

   // subkey table write data
   always_comb begin
      case (ctl.wd_sel)
         WSEL_ZERO: ram_wdata = '0;
         WSEL_ACC:  ram_wdata = a_ff;
         WSEL_ALU:  ram_wdata = alu_res;
         default:   ram_wdata = '0;
      endcase
   end

   rc5_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_WORDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ctl.ram_we),
      .wr_addr (waddr),
      .wr_data (ram_wdata),
      .rd_addr (raddr),
      .rd_data (ram_rdata)
   );

   // working words a and b
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      if (ctl.ld_req) begin
         a_in = req_word.word_a;
         b_in = req_word.word_b;
      end else if (ctl.ld_magic) begin
         a_in = MAGIC_P;
      end else if (ctl.ab_clr) begin
         a_in = '0;
         b_in = '0;
      end else begin
         if (ctl.a_we) a_in = alu_res;
         if (ctl.b_we) b_in = alu_res;
      end
   end

   // key word scratch for the mixing steps
   always_comb begin
      for (int w = 0; w < KEY_WORDS; w++) begin
         if (ctl.l_load) begin
            l_in[w] = key_word[w];
         end else if (ctl.l_we && (l_idx == KIDX_W'(w))) begin
            l_in[w] = alu_res;
         end else begin
            l_in[w] = l_ff[w];
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      for (int w = 0; w < KEY_WORDS; w++) begin
         l_ff[w] <= l_in[w];
      end
   end

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl.rsp_fire;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_word.out_a = a_ff;
   assign rsp_word.out_b = b_ff;

   // checks
   `RC5_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_strobe, !busy, "response while busy")
   `RC5_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_strobe, !rsp_strobe, "strobe held")
   `RC5_ASSERT_NEXT(a_cmd_busy, clock, reset,
      (start && !busy && (req_word.cmd != CMD_UNUSED)), busy, "command not started")

endmodule

// ===== rtl/rc5_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rc5_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 26
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rc5_alu.sv =====
// shared add, subtract, xor and rotate unit used by every cipher and key schedule step
// depends on rc5_pkg
`timescale 1ns / 1ps

module rc5_alu
   import rc5_pkg::*;
(
   input  alu_op_type        op,
   input  logic [WORD_W-1:0] x,
   input  logic [WORD_W-1:0] y,
   input  logic [WORD_W-1:0] s,
   output logic [WORD_W-1:0] res
);

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                              input logic [4:0] n);
      logic [2*WORD_W-1:0] d;
      d = {v, v} << n;
      return d[2*WORD_W-1:WORD_W];
   endfunction

   function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v,
                                              input logic [4:0] n);
      logic [2*WORD_W-1:0] d;
      d = {v, v} >> n;
      return d[WORD_W-1:0];
   endfunction

   logic [WORD_W-1:0] xy_sum;
   logic [WORD_W-1:0] xys_sum;

   assign xy_sum  = x + y;
   assign xys_sum = xy_sum + s;

   // operation select
   always_comb begin
      case (op)
         OP_ADD:   res = x + s;
         OP_SUB:   res = x - s;
         OP_ENC:   res = rotl(x ^ y, y[4:0]) + s;
         OP_DEC:   res = rotr(x - s, y[4:0]) ^ y;
         OP_MIX_A: res = rotl(xys_sum, 5'd3);
         OP_MIX_B: res = rotl(xys_sum, xy_sum[4:0]);
         default:  res = x;
      endcase
   end

endmodule

// ===== rtl/rc5_seq.sv =====
// sequencer for table clear, key expansion, encrypt and decrypt
// depends on rc5_pkg
`timescale 1ns / 1ps

module rc5_seq
   import rc5_pkg::*;
#(
   parameter int TABLE_WORDS = 2 * RC5_ROUNDS + 2,
   parameter int KEY_WORDS   = (RC5_KEY_BYTES + 3) / 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [1:0]                     cmd,
   output logic                           busy,
   output ctl_type                        ctl,
   output logic [$clog2(TABLE_WORDS)-1:0] raddr,
   output logic [$clog2(TABLE_WORDS)-1:0] waddr,
   output logic [((KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1)-1:0] l_idx
);

   localparam int ADDR_W = $clog2(TABLE_WORDS);
   localparam int KIDX_W = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
   localparam logic [ADDR_W-1:0] LAST_K = ADDR_W'(TABLE_WORDS - 1);
   localparam logic [KIDX_W-1:0] LAST_J = KIDX_W'(KEY_WORDS - 1);
   localparam logic [1:0]        LAST_PASS = 2'(MIX_PASSES - 1);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic [KIDX_W-1:0] j_ff, j_in;
   logic [1:0]        pass_ff, pass_in;

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         k_ff     <= '0;
         j_ff     <= '0;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         j_ff     <= j_in;
         pass_ff  <= pass_in;
      end
   end

   // next state and step controls
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      pass_in  = pass_ff;
      ctl      = '{op: OP_ADD, s_sel: SSEL_RAM, wd_sel: WSEL_ZERO, default: 1'b0};
      case (state_ff)
         ST_CLEAR: begin
            ctl.ram_we = 1'b1;
            ctl.wd_sel = WSEL_ZERO;
            if (k_ff == LAST_K) begin
               k_in     = '0;
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               case (cmd)
                  CMD_EXPAND: begin
                     ctl.ld_magic = 1'b1;
                     ctl.l_load   = 1'b1;
                     k_in         = '0;
                     state_in     = ST_INIT;
                  end
                  CMD_ENCRYPT: begin
                     ctl.ld_req = 1'b1;
                     k_in       = '0;
                     state_in   = ST_ENC;
                  end
                  CMD_DECRYPT: begin
                     ctl.ld_req = 1'b1;
                     k_in       = LAST_K;
                     state_in   = ST_DEC;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         // fill the table with the arithmetic progression p + i*q
         ST_INIT: begin
            ctl.ram_we = 1'b1;
            ctl.wd_sel = WSEL_ACC;
            ctl.op     = OP_ADD;
            ctl.s_sel  = SSEL_MAGIC;
            ctl.a_we   = 1'b1;
            if (k_ff == LAST_K) begin
               ctl.ab_clr = 1'b1;
               k_in       = '0;
               j_in       = '0;
               pass_in    = '0;
               state_in   = ST_MIX_A;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         // subkey half of a mixing step
         ST_MIX_A: begin
            ctl.op     = OP_MIX_A;
            ctl.s_sel  = SSEL_RAM;
            ctl.a_we   = 1'b1;
            ctl.ram_we = 1'b1;
            ctl.wd_sel = WSEL_ALU;
            state_in   = ST_MIX_B;
         end
         // key word half of a mixing step
         ST_MIX_B: begin
            ctl.op    = OP_MIX_B;
            ctl.s_sel = SSEL_KEY;
            ctl.b_we  = 1'b1;
            ctl.l_we  = 1'b1;
            j_in      = (j_ff == LAST_J) ? '0 : j_ff + 1'b1;
            state_in  = ST_MIX_A;
            if (k_ff == LAST_K) begin
               k_in = '0;
               if (pass_ff == LAST_PASS) begin
                  state_in = ST_IDLE;
               end else begin
                  pass_in = pass_ff + 1'b1;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         // one half round per cycle, subkeys in ascending order
         ST_ENC: begin
            ctl.s_sel = SSEL_RAM;
            if (k_ff == '0) begin
               ctl.op   = OP_ADD;
               ctl.a_we = 1'b1;
            end else if (k_ff == ADDR_W'(1)) begin
               ctl.op   = OP_ADD;
               ctl.swap = 1'b1;
               ctl.b_we = 1'b1;
            end else begin
               ctl.op   = OP_ENC;
               ctl.swap = k_ff[0];
               ctl.a_we = ~k_ff[0];
               ctl.b_we = k_ff[0];
            end
            if (k_ff == LAST_K) begin
               ctl.rsp_fire = 1'b1;
               k_in         = '0;
               state_in     = ST_IDLE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         // one half round per cycle, subkeys in descending order
         ST_DEC: begin
            ctl.s_sel = SSEL_RAM;
            if (k_ff == '0) begin
               ctl.op       = OP_SUB;
               ctl.a_we     = 1'b1;
               ctl.rsp_fire = 1'b1;
               state_in     = ST_IDLE;
            end else if (k_ff == ADDR_W'(1)) begin
               ctl.op   = OP_SUB;
               ctl.swap = 1'b1;
               ctl.b_we = 1'b1;
            end else begin
               ctl.op   = OP_DEC;
               ctl.swap = k_ff[0];
               ctl.a_we = ~k_ff[0];
               ctl.b_we = k_ff[0];
            end
            if (k_ff != '0) begin
               k_in = k_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            k_in     = '0;
         end
      endcase
   end

   // read one step ahead so registered ram data lines up with the step
   assign raddr = k_in;
   assign waddr = k_ff;
   assign l_idx = j_ff;
   assign busy  = (state_ff != ST_IDLE);

endmodule
